### design/dwpi_pkg.sv
// Shared types, widths and constants of the dual-wheel PI speed controller.
package dwpi_pkg;

   localparam int Q_W        = 25;  // Q24 fractions and gains, 0 .. 2^24 inclusive
   localparam int Q_FRAC     = 24;
   localparam int PERIOD_W   = 15;
   localparam int DUTY_W     = 16;
   localparam int DIST_W     = 32;
   localparam int INTEG_W    = 32;
   localparam int TARGET_W   = 7;
   localparam int COUNT_W    = 16;
   localparam int ERR_W      = 17;
   localparam int MUL_A_W    = INTEG_W + 1;
   localparam int MUL_B_W    = Q_W + 1;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int ACC_W      = PROD_W + 3;
   localparam int CSR_INDEX_W = 3;
   localparam int DEF_QUEUE_DEPTH = 2;

   localparam logic [TARGET_W-1:0] MAX_TARGET = 7'd75;

   // duty at reset: (2 * 5580 * 10066330) >> 24
   localparam logic [DUTY_W-1:0] DUTY_RESET = 16'd6696;

   localparam logic [PERIOD_W-1:0] PWM_PERIOD_RESET = 15'd5580;
   localparam logic [Q_W-1:0] PROP_GAIN_RESET  = 25'd16777;
   localparam logic [Q_W-1:0] INTEG_GAIN_RESET = 25'd1678;
   localparam logic [Q_W-1:0] FWD_BASE_RESET   = 25'd10066330;
   localparam logic [Q_W-1:0] FWD_MAX_RESET    = 25'd13421773;
   localparam logic [Q_W-1:0] REV_BASE_RESET   = 25'd9563013;
   localparam logic [Q_W-1:0] REV_MIN_RESET    = 25'd5033165;
   localparam logic [Q_W-1:0] STARTUP_RESET    = 25'd10569646;

   // command byte kinds, bits 7-5
   localparam logic [2:0] CMD_KIND_SET     = 3'b100;
   localparam logic [2:0] CMD_KIND_SET_ALT = 3'b111;
   localparam logic [2:0] CMD_KIND_CLEAR   = 3'b110;

   localparam logic OP_COMMAND = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PWM_PERIOD = 3'd0,
      REG_PROP_GAIN  = 3'd1,
      REG_INTEG_GAIN = 3'd2,
      REG_FWD_BASE   = 3'd3,
      REG_FWD_MAX    = 3'd4,
      REG_REV_BASE   = 3'd5,
      REG_REV_MIN    = 3'd6,
      REG_STARTUP    = 3'd7
   } csr_reg_type;

   typedef enum logic [1:0] {
      KIND_NOP,
      KIND_SET,
      KIND_CLEAR,
      KIND_TICK
   } item_kind_type;

   typedef struct packed {
      logic                       operation;
      logic [7:0]                 command_byte;
      logic signed [COUNT_W-1:0]  count_left;
      logic signed [COUNT_W-1:0]  count_right;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0]          duty_left;
      logic [DUTY_W-1:0]          duty_right;
      logic                       reverse_mode;
      logic [TARGET_W-1:0]        speed_target;
      logic signed [DIST_W-1:0]   distance_total;
   } rsp_type;

   // classified request as it sits in the queue
   typedef struct packed {
      item_kind_type              kind;
      logic                       reverse;
      logic [TARGET_W-1:0]        target;
      logic signed [COUNT_W-1:0]  count_left;
      logic signed [COUNT_W-1:0]  count_right;
   } item_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] pwm_period;
      logic [Q_W-1:0]      prop_gain;
      logic [Q_W-1:0]      integ_gain;
      logic [Q_W-1:0]      fwd_base;
      logic [Q_W-1:0]      fwd_max;
      logic [Q_W-1:0]      rev_base;
      logic [Q_W-1:0]      rev_min;
      logic [Q_W-1:0]      startup;
   } cfg_type;

endpackage

### design/dwpi_fifo.sv
// Small register queue between the request decoder and the control sequencer.
module dwpi_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/dwpi_front.sv
// Request intake: classifies commands and ticks and hands them to the queue.
module dwpi_front import dwpi_pkg::*; (
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   input  logic     queue_full,
   output logic     push_valid,
   output item_type push_item
);

   logic [2:0] cmd_kind;
   logic [3:0] speed_code;

   assign cmd_kind   = req_data.command_byte[7:5];
   assign speed_code = req_data.command_byte[3:0];

   assign req_stall  = queue_full;
   assign push_valid = req_valid;

   always_comb begin
      push_item.reverse     = req_data.command_byte[4];
      // speed code times five
      push_item.target      = TARGET_W'({speed_code, 2'b00}) + TARGET_W'(speed_code);
      push_item.count_left  = req_data.count_left;
      push_item.count_right = req_data.count_right;
      priority if (req_data.operation == OP_TICK) begin
         push_item.kind = KIND_TICK;
      end else if (cmd_kind == CMD_KIND_SET || cmd_kind == CMD_KIND_SET_ALT) begin
         push_item.kind = KIND_SET;
      end else if (cmd_kind == CMD_KIND_CLEAR) begin
         push_item.kind = KIND_CLEAR;
      end else begin
         push_item.kind = KIND_NOP;
      end
   end

endmodule

### design/dwpi_csr.sv
// Configuration register bank of the speed controller.
module dwpi_csr import dwpi_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [Q_W-1:0]         csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pwm_period <= PWM_PERIOD_RESET;
         cfg_ff.prop_gain  <= PROP_GAIN_RESET;
         cfg_ff.integ_gain <= INTEG_GAIN_RESET;
         cfg_ff.fwd_base   <= FWD_BASE_RESET;
         cfg_ff.fwd_max    <= FWD_MAX_RESET;
         cfg_ff.rev_base   <= REV_BASE_RESET;
         cfg_ff.rev_min    <= REV_MIN_RESET;
         cfg_ff.startup    <= STARTUP_RESET;
      end else if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            REG_PWM_PERIOD: cfg_ff.pwm_period <= csr_data[PERIOD_W-1:0];
            REG_PROP_GAIN:  cfg_ff.prop_gain  <= csr_data;
            REG_INTEG_GAIN: cfg_ff.integ_gain <= csr_data;
            REG_FWD_BASE:   cfg_ff.fwd_base   <= csr_data;
            REG_FWD_MAX:    cfg_ff.fwd_max    <= csr_data;
            REG_REV_BASE:   cfg_ff.rev_base   <= csr_data;
            REG_REV_MIN:    cfg_ff.rev_min    <= csr_data;
            REG_STARTUP:    cfg_ff.startup    <= csr_data;
         endcase
      end
   end

endmodule

### design/dwpi_back.sv
// Control sequencer: controller state, shared multiplier and result register.
module dwpi_back import dwpi_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     queue_empty,
   input  item_type queue_item,
   output logic     queue_pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ERR,
      ST_MUL_P,
      ST_MUL_I,
      ST_ADD,
      ST_BASE,
      ST_CLAMP,
      ST_MUL_D,
      ST_DUTY,
      ST_OUT
   } state_type;

   state_type                  state_ff;
   item_type                   item_ff;
   logic                       wheel_ff;   // 0 left, 1 right
   logic                       first_ff;   // startup tick in flight
   logic                       started_ff;
   logic                       reverse_ff;
   logic [TARGET_W-1:0]        target_ff;
   logic signed [INTEG_W-1:0]  integ_left_ff;
   logic signed [INTEG_W-1:0]  integ_right_ff;
   logic [DUTY_W-1:0]          duty_left_ff;
   logic [DUTY_W-1:0]          duty_right_ff;
   logic [DIST_W-1:0]          dist_ff;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_data_ff;

   logic signed [ERR_W-1:0]    err_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic [Q_W-1:0]             frac_ff;

   logic signed [COUNT_W-1:0]  count_sel;
   logic signed [INTEG_W-1:0]  integ_sel;
   logic signed [ERR_W-1:0]    err_in;
   logic [INTEG_W:0]           integ_sum;
   logic signed [INTEG_W-1:0]  integ_in;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [ACC_W-1:0]    prod_ext;
   logic signed [ACC_W-1:0]    fwd_base_ext;
   logic signed [ACC_W-1:0]    fwd_max_ext;
   logic signed [ACC_W-1:0]    rev_base_ext;
   logic signed [ACC_W-1:0]    rev_min_ext;
   logic [Q_W-1:0]             frac_in;
   logic [DUTY_W:0]            duty_raw;
   logic [DUTY_W-1:0]          duty_in;
   logic                       out_free;

   assign queue_pop = (state_ff == ST_IDLE) && !queue_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign count_sel = wheel_ff ? item_ff.count_right : item_ff.count_left;
   assign integ_sel = wheel_ff ? integ_right_ff : integ_left_ff;

   assign err_in = $signed({{(ERR_W-TARGET_W){1'b0}}, target_ff})
                 - $signed({{(ERR_W-COUNT_W){count_sel[COUNT_W-1]}}, count_sel});

   // saturating integral update
   assign integ_sum = {integ_sel[INTEG_W-1], integ_sel}
                    + {{(INTEG_W+1-ERR_W){err_in[ERR_W-1]}}, err_in};
   always_comb begin
      if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
         integ_in = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                       : {1'b0, {(INTEG_W-1){1'b1}}};
      end else begin
         integ_in = integ_sum[INTEG_W-1:0];
      end
   end

   // one shared multiplier: P term, I term, then duty scaling
   always_comb begin
      unique case (state_ff)
         ST_MUL_P: begin
            mul_a = {{(MUL_A_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
            mul_b = {1'b0, cfg.prop_gain};
         end
         ST_MUL_I: begin
            mul_a = {integ_sel[INTEG_W-1], integ_sel};
            mul_b = {1'b0, cfg.integ_gain};
         end
         default: begin
            mul_a = {{(MUL_A_W-PERIOD_W-1){1'b0}}, cfg.pwm_period, 1'b0};
            mul_b = {1'b0, frac_ff};
         end
      endcase
   end

   assign prod_ext     = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign fwd_base_ext = $signed({{(ACC_W-Q_W){1'b0}}, cfg.fwd_base});
   assign fwd_max_ext  = $signed({{(ACC_W-Q_W){1'b0}}, cfg.fwd_max});
   assign rev_base_ext = $signed({{(ACC_W-Q_W){1'b0}}, cfg.rev_base});
   assign rev_min_ext  = $signed({{(ACC_W-Q_W){1'b0}}, cfg.rev_min});

   always_comb begin
      priority if (first_ff) begin
         frac_in = cfg.startup;
      end else if (target_ff == '0) begin
         frac_in = cfg.fwd_base;
      end else if (!reverse_ff) begin
         priority if (acc_ff < fwd_base_ext) begin
            frac_in = cfg.fwd_base;
         end else if (acc_ff > fwd_max_ext) begin
            frac_in = cfg.fwd_max;
         end else begin
            frac_in = acc_ff[Q_W-1:0];
         end
      end else begin
         priority if (acc_ff < rev_min_ext) begin
            frac_in = cfg.rev_min;
         end else if (acc_ff > rev_base_ext) begin
            frac_in = cfg.rev_base;
         end else begin
            frac_in = acc_ff[Q_W-1:0];
         end
      end
   end

   assign duty_raw = prod_ff[Q_FRAC+DUTY_W:Q_FRAC];
   assign duty_in  = duty_raw[DUTY_W] ? '1 : duty_raw[DUTY_W-1:0];

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      unique case (state_ff)
         ST_ERR:   err_ff  <= err_in;
         ST_MUL_I: acc_ff  <= prod_ext;
         ST_ADD:   acc_ff  <= acc_ff + prod_ext;
         ST_BASE:  acc_ff  <= reverse_ff ? rev_base_ext - acc_ff : fwd_base_ext + acc_ff;
         ST_CLAMP: frac_ff <= frac_in;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         wheel_ff       <= 1'b0;
         first_ff       <= 1'b0;
         started_ff     <= 1'b0;
         reverse_ff     <= 1'b0;
         target_ff      <= '0;
         integ_left_ff  <= '0;
         integ_right_ff <= '0;
         duty_left_ff   <= DUTY_RESET;
         duty_right_ff  <= DUTY_RESET;
         dist_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!queue_empty) begin
                  item_ff  <= queue_item;
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               wheel_ff <= 1'b0;
               first_ff <= (item_ff.kind == KIND_TICK) && !started_ff;
               unique case (item_ff.kind)
                  KIND_SET: begin
                     reverse_ff <= item_ff.reverse;
                     target_ff  <= item_ff.target;
                     if (item_ff.reverse) begin
                        dist_ff <= '0;
                     end
                     state_ff <= ST_OUT;
                  end
                  KIND_CLEAR: begin
                     dist_ff  <= '0;
                     state_ff <= ST_OUT;
                  end
                  KIND_NOP: begin
                     state_ff <= ST_OUT;
                  end
                  KIND_TICK: begin
                     if (started_ff) begin
                        state_ff <= ST_ERR;
                     end else begin
                        // first tick: startup duty only
                        started_ff <= 1'b1;
                        state_ff   <= ST_CLAMP;
                     end
                  end
               endcase
            end
            ST_ERR: begin
               if (wheel_ff) begin
                  integ_right_ff <= integ_in;
               end else begin
                  integ_left_ff <= integ_in;
                  dist_ff <= dist_ff
                           + {{(DIST_W-COUNT_W){item_ff.count_left[COUNT_W-1]}},
                              item_ff.count_left};
               end
               state_ff <= ST_MUL_P;
            end
            ST_MUL_P: state_ff <= ST_MUL_I;
            ST_MUL_I: state_ff <= ST_ADD;
            ST_ADD:   state_ff <= ST_BASE;
            ST_BASE:  state_ff <= ST_CLAMP;
            ST_CLAMP: state_ff <= ST_MUL_D;
            ST_MUL_D: state_ff <= ST_DUTY;
            ST_DUTY: begin
               if (first_ff) begin
                  duty_left_ff  <= duty_in;
                  duty_right_ff <= duty_in;
                  state_ff      <= ST_OUT;
               end else if (!wheel_ff) begin
                  duty_left_ff <= duty_in;
                  wheel_ff     <= 1'b1;
                  state_ff     <= ST_ERR;
               end else begin
                  duty_right_ff <= duty_in;
                  state_ff      <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff                <= 1'b1;
                  rsp_data_ff.duty_left       <= duty_left_ff;
                  rsp_data_ff.duty_right      <= duty_right_ff;
                  rsp_data_ff.reverse_mode    <= reverse_ff;
                  rsp_data_ff.speed_target    <= target_ff;
                  rsp_data_ff.distance_total  <= $signed(dist_ff);
                  state_ff                    <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

### design/dual_wheel_pi_speed_controller.sv
// Two-wheel PI speed controller, top level.
//
// Requests arrive on req_valid/req_stall with req_data: a command byte
// (set direction and target, or clear distance) or a control tick carrying
// the left and right encoder deltas. Every request gives exactly one
// response on rsp_valid/rsp_stall with both PWM duties, direction, target
// and the accumulated left distance.
// Requests are decoded and held in a queue of QUEUE_DEPTH entries; a
// sequencer with one shared multiplier works on one request at a time.
// A command goes from decode straight to the output step; the first tick
// after reset runs only the clamp, duty and output steps, and every later
// tick runs both wheels in turn (two wheels, eight steps each).
// The response sits in an output register: while rsp_stall is high it holds
// and the queue keeps taking requests until full, then req_stall rises.
// Configuration: csr_valid with csr_index/csr_data, always ready; write only
// while the block is idle. Synchronous reset restores register defaults,
// clears the controller state and sets both duties to the forward base duty.
module dual_wheel_pi_speed_controller import dwpi_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [Q_W-1:0]         csr_data
);

   cfg_type  cfg;
   logic     queue_full;
   logic     queue_empty;
   logic     queue_pop;
   logic     push_valid;
   item_type push_item;
   item_type pop_item;

   dwpi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dwpi_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   dwpi_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (pop_item),
      .empty     (queue_empty)
   );

   dwpi_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .queue_empty (queue_empty),
      .queue_item  (pop_item),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

### design/dwpi_checker.sv
// Port-level assertions for the speed controller, bound to the top level.
module dwpi_checker import dwpi_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic [7:0] pending_ff;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   // requests taken but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (req_acc && !rsp_acc) begin
         pending_ff <= pending_ff + 1'b1;
      end else if (rsp_acc && !req_acc) begin
         pending_ff <= pending_ff - 1'b1;
      end
   end

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("response without an outstanding request");

   a_target_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.speed_target <= MAX_TARGET)
      else $error("speed target out of range");

endmodule

bind dual_wheel_pi_speed_controller dwpi_checker u_checker (.*);
